// ----- hdl/xsfb_pkg.sv -----
// Shared constants, types and lookup tables for the XOR sprite framebuffer.
`timescale 1ns / 1ps

package xsfb_pkg;

  // Screen geometry: width 8..64 columns, height 8..64 rows
  localparam int SCREEN_WIDTH_PX  = 64;
  localparam int SCREEN_HEIGHT_PX = 32;

  // Fixed field widths of the transaction payloads
  localparam int OP_W       = 2;
  localparam int COORD_W    = 8;
  localparam int SPRITE_W   = 8;
  localparam int ROW_BITS_W = 64;

  // Internal widths derived from the geometry
  localparam int ROW_W     = $clog2(SCREEN_HEIGHT_PX);
  localparam int COL_W     = $clog2(SCREEN_WIDTH_PX);
  localparam int COORD_CNT = 1 << COORD_W;

  typedef enum logic [OP_W-1:0] {
    OP_DRAW  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture the accepted request
    logic exec;  // update the screen and load the result register
  } ctl_t;

  typedef logic [ROW_W-1:0] row_lut_t [COORD_CNT];
  typedef logic [COL_W-1:0] col_lut_t [COORD_CNT];

  // Coordinate wrap tables, built at elaboration
  function automatic row_lut_t build_row_lut();
    row_lut_t lut;
    for (int i = 0; i < COORD_CNT; i++) begin
      lut[i] = ROW_W'(i % SCREEN_HEIGHT_PX);
    end
    return lut;
  endfunction

  function automatic col_lut_t build_col_lut();
    col_lut_t lut;
    for (int i = 0; i < COORD_CNT; i++) begin
      lut[i] = COL_W'(i % SCREEN_WIDTH_PX);
    end
    return lut;
  endfunction

  localparam row_lut_t ROW_LUT = build_row_lut();
  localparam col_lut_t COL_LUT = build_col_lut();

endpackage

// ----- hdl/xsfb_req_if.sv -----
// Request channel: operation, coordinates and sprite byte with valid/ready.
`timescale 1ns / 1ps

interface xsfb_req_if import xsfb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [COORD_W-1:0]  x_pos;
  logic [COORD_W-1:0]  y_pos;
  logic [SPRITE_W-1:0] sprite_byte;

  modport source (output valid, output op, output x_pos, output y_pos,
                  output sprite_byte, input ready);
  modport sink   (input valid, input op, input x_pos, input y_pos,
                  input sprite_byte, output ready);
endinterface

// ----- hdl/xsfb_rsp_if.sv -----
// Response channel: collision flag and row pixels with valid/ready.
`timescale 1ns / 1ps

interface xsfb_rsp_if import xsfb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  collision;
  logic [ROW_BITS_W-1:0] row_bits;

  modport source (output valid, output collision, output row_bits, input ready);
  modport sink   (input valid, input collision, input row_bits, output ready);
endinterface

// ----- hdl/xsfb_ctrl.sv -----
// Controller: accept a transaction, execute it, and track the result register.
`timescale 1ns / 1ps

module xsfb_ctrl import xsfb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output ctl_t ctl
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // Accept only when idle; execute once the result register can take data
  assign in_ready = (state == S_IDLE);
  assign ctl.load = in_valid && (state == S_IDLE);
  assign ctl.exec = (state == S_EXEC) && (!out_valid || out_ready);

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          if (ctl.exec) state <= S_IDLE;
        end
      endcase
      if (ctl.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/xsfb_dp.sv -----
// Datapath: screen rows, sprite mask build, XOR update and result register.
`timescale 1ns / 1ps

module xsfb_dp import xsfb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_t                  ctl,
  input  logic [OP_W-1:0]       op,
  input  logic [COORD_W-1:0]    x_pos,
  input  logic [COORD_W-1:0]    y_pos,
  input  logic [SPRITE_W-1:0]   sprite_byte,
  output logic                  collision,
  output logic [ROW_BITS_W-1:0] row_bits
);

  localparam logic [COL_W:0] WIDTH_C = (COL_W+1)'(SCREEN_WIDTH_PX);

  // Captured request, coordinates already wrapped
  logic [OP_W-1:0]     op_q;
  logic [ROW_W-1:0]    row_q;
  logic [COL_W-1:0]    col_q;
  logic [SPRITE_W-1:0] spr_q;

  logic [SCREEN_WIDTH_PX-1:0] screen [SCREEN_HEIGHT_PX];

  logic [SCREEN_WIDTH_PX-1:0] cur_row;
  logic [SCREEN_WIDTH_PX-1:0] mask;
  logic [SCREEN_WIDTH_PX-1:0] new_row;
  logic                       hit;

  // Capture the request and wrap its coordinates
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_q  <= op;
      row_q <= ROW_LUT[y_pos];
      col_q <= COL_LUT[x_pos];
      spr_q <= sprite_byte;
    end
  end

  // Build the sprite mask; bit 7 lands at the base column
  always_comb begin
    logic [COL_W:0]   sum;
    logic [COL_W-1:0] col;
    mask = '0;
    for (int i = 0; i < SPRITE_W; i++) begin
      sum = {1'b0, col_q} + (COL_W+1)'(SPRITE_W - 1 - i);
      if (sum >= WIDTH_C) sum = sum - WIDTH_C;
      col = sum[COL_W-1:0];
      if (spr_q[i]) mask[col] = 1'b1;
    end
  end

  // Read-modify-write the addressed row
  assign cur_row = screen[row_q];
  assign hit     = |(cur_row & mask);
  assign new_row = cur_row ^ mask;

  // Update screen state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < SCREEN_HEIGHT_PX; r++) screen[r] <= '0;
    end else if (ctl.exec) begin
      if (op_q == OP_DRAW) begin
        screen[row_q] <= new_row;
      end else if (op_q == OP_CLEAR) begin
        for (int r = 0; r < SCREEN_HEIGHT_PX; r++) screen[r] <= '0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      if (op_q == OP_DRAW) begin
        collision <= hit;
        row_bits  <= ROW_BITS_W'(new_row);
      end else if (op_q == OP_CLEAR) begin
        collision <= 1'b0;
        row_bits  <= '0;
      end else begin
        collision <= 1'b0;
        row_bits  <= ROW_BITS_W'(cur_row);
      end
    end
  end

endmodule

// ----- hdl/xor_sprite_framebuffer_core.sv -----
// An accepted request is captured, then executed, and the result register
// is loaded by the execute step; no new request is taken until that step is
// done, and a stalled result delays the execute step.
// The screen row update is one read-modify-write in the execute cycle.
// Reset (rst, synchronous): clears the whole screen and empties the result
// register; no request is accepted while rst is high.
`timescale 1ns / 1ps

module xor_sprite_framebuffer_core import xsfb_pkg::*; (
  input logic      clk,
  input logic      rst,
  xsfb_req_if.sink req,
  xsfb_rsp_if.source rsp
);

  ctl_t ctl;
  logic in_ready;
  logic out_valid;

  // Sequence each transaction
  xsfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid && !rst),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .ctl       (ctl)
  );

  // Screen state and result data
  xsfb_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .op          (req.op),
    .x_pos       (req.x_pos),
    .y_pos       (req.y_pos),
    .sprite_byte (req.sprite_byte),
    .collision   (rsp.collision),
    .row_bits    (rsp.row_bits)
  );

  assign req.ready = in_ready && !rst;
  assign rsp.valid = out_valid;

`ifndef NO_ASSERTIONS
  // Block goes busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while previous one still executing");

  // Execute never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (ctl.exec && rsp.valid) |-> rsp.ready)
    else $error("pending result overwritten");

  // Every execute step presents a result on the next cycle
  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    ctl.exec |=> rsp.valid)
    else $error("execute step produced no result");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp.valid)
    else $error("result valid after reset");
`endif

endmodule

// ----- verif/xor_sprite_framebuffer_core_tb.sv -----
// Self-checking testbench for the XOR sprite framebuffer core: draw, clear and read traffic.
`timescale 1ns / 1ps

module xor_sprite_framebuffer_core_tb;
  import xsfb_pkg::*;

  // Op 3 is not in the package enum; the core treats it as a read
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [ROW_BITS_W-1:0] ROW_MASK =
    {ROW_BITS_W{1'b1}} >> (ROW_BITS_W - SCREEN_WIDTH_PX);

  typedef struct packed {
    logic                  collision;
    logic [ROW_BITS_W-1:0] row_bits;
  } row_result_t;

  logic clk = 1'b0;
  logic rst;

  xsfb_req_if req_ch ();
  xsfb_rsp_if rsp_ch ();

  xor_sprite_framebuffer_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the screen and the rows still owed by the core
  logic [ROW_BITS_W-1:0] shadow_screen [SCREEN_HEIGHT_PX];
  row_result_t           pending_rows [$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  bit          req_gaps_on = 1'b1;
  bit          rsp_stalls_on = 1'b1;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one transaction to the shadow screen and return the row it reports
  function automatic row_result_t framebuffer_update(input logic [OP_W-1:0] op,
                                                     input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y,
                                                     input logic [SPRITE_W-1:0] sprite);
    row_result_t           res;
    logic [ROW_BITS_W-1:0] sprite_mask;
    int                    row;
    int                    col;
    sprite_mask   = '0;
    row           = int'(y) % SCREEN_HEIGHT_PX;
    res.collision = 1'b0;
    if (op == OP_DRAW) begin
      // Bit 7 lands on column x, bit 0 on column x+7, both wrapped
      for (int i = 0; i < SPRITE_W; i++) begin
        if (sprite[i]) begin
          col = (int'(x) + SPRITE_W - 1 - i) % SCREEN_WIDTH_PX;
          sprite_mask[col] = 1'b1;
        end
      end
      sprite_mask &= ROW_MASK;
      res.collision = |(shadow_screen[row] & sprite_mask);
      shadow_screen[row] = (shadow_screen[row] ^ sprite_mask) & ROW_MASK;
    end else if (op == OP_CLEAR) begin
      foreach (shadow_screen[r]) shadow_screen[r] = '0;
    end
    res.row_bits = shadow_screen[row] & ROW_MASK;
    return res;
  endfunction

  // Drive one request, wait for acceptance, then maybe idle for a burst
  task automatic send_item(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [SPRITE_W-1:0] sprite);
    req_ch.valid       <= 1'b1;
    req_ch.op          <= op;
    req_ch.x_pos       <= x;
    req_ch.y_pos       <= y;
    req_ch.sprite_byte <= sprite;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_rows.push_back(framebuffer_update(op, x, y, sprite));
    if (req_gaps_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic stop_sending();
    req_ch.valid <= 1'b0;
  endtask

  // Hold until every owed row has come back, then let the pipeline settle
  task automatic wait_results_drained();
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Draws at the field extremes, with wrap and collision cases
  task automatic test_draw_extremes();
    send_item(OP_DRAW, 8'd0,   8'd0,   8'hFF);  // light columns 0..7 of row 0
    send_item(OP_DRAW, 8'd0,   8'd0,   8'hFF);  // same byte again: all collide, row dark
    send_item(OP_DRAW, 8'd255, 8'd255, 8'hFF);  // column 63 then wrap to 0..6, row 31
    send_item(OP_DRAW, 8'd60,  8'd63,  8'hA5);  // right edge straddle, partial collision
    send_item(OP_DRAW, 8'd128, 8'd32,  8'h80);  // both coordinates wrap to zero
    send_item(OP_DRAW, 8'd7,   8'd0,   8'h01);  // lone low bit lands on column 14
    send_item(OP_DRAW, 8'd3,   8'd0,   8'h00);  // empty byte: no change, no collision
    send_item(OP_DRAW, 8'd129, 8'd0,   8'h7F);  // next to lit pixels, no overlap
    send_item(OP_DRAW, 8'd56,  8'd31,  8'hFF);  // last columns of the last row
    send_item(OP_DRAW, 8'd170, 8'd85,  8'h55);  // alternating coordinate and sprite bits
  endtask

  // Read, unused op, and clear, with draws around the clear
  task automatic test_other_ops();
    send_item(OP_READ,   8'd0,   8'd0,   8'h00);
    send_item(OP_READ,   8'd255, 8'd255, 8'hFF);  // sprite and x ignored
    send_item(OP_UNUSED, 8'd33,  8'd31,  8'hAA);  // behaves as a read
    send_item(OP_DRAW,   8'd62,  8'd5,   8'hC3);
    send_item(OP_UNUSED, 8'd0,   8'd5,   8'hFF);  // must not draw
    send_item(OP_CLEAR,  8'd255, 8'd200, 8'h5A);  // blanks every row, reports row 8
    send_item(OP_READ,   8'd0,   8'd31,  8'h00);
    send_item(OP_READ,   8'd0,   8'd5,   8'h00);
    send_item(OP_DRAW,   8'd0,   8'd5,   8'hFF);  // draw on a blank screen: no collision
    send_item(OP_CLEAR,  8'd0,   8'd5,   8'h00);  // clear right after a draw
    send_item(OP_READ,   8'd0,   8'd5,   8'h00);
  endtask

  // Random mix: mostly draws on a few rows so pixels pile up and collide
  task automatic test_random_traffic(input int unsigned count);
    int unsigned kind;
    logic [COORD_W-1:0] y;
    for (int unsigned n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 1) == 0) begin
        y = COORD_W'($urandom_range(0, 7) + SCREEN_HEIGHT_PX * $urandom_range(0, 7));
      end else begin
        y = COORD_W'($urandom_range(0, 255));
      end
      if (kind < 70) begin
        send_item(OP_DRAW, COORD_W'($urandom_range(0, 255)), y,
                  SPRITE_W'($urandom_range(0, 255)));
      end else if (kind < 90) begin
        send_item(OP_READ, COORD_W'($urandom_range(0, 255)), y,
                  SPRITE_W'($urandom_range(0, 255)));
      end else if (kind < 97) begin
        send_item(OP_UNUSED, COORD_W'($urandom_range(0, 255)), y,
                  SPRITE_W'($urandom_range(0, 255)));
      end else begin
        send_item(OP_CLEAR, COORD_W'($urandom_range(0, 255)), y,
                  SPRITE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // Sender holds off until the core has returned everything, then resumes
  task automatic test_drain_pause();
    stop_sending();
    wait_results_drained();
    send_item(OP_READ, 8'd0, 8'd0,  8'h00);
    send_item(OP_DRAW, 8'd0, 8'd0,  8'h18);
  endtask

  // Result sink: drop ready in random bursts while stalls are enabled
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (rsp_stalls_on && $urandom_range(0, 4) == 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 13);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest owed row
  always @(posedge clk) begin
    row_result_t owed;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual collision=%0b row_bits=%h",
                 $time, rsp_ch.collision, rsp_ch.row_bits);
        fail_count++;
      end else begin
        owed = pending_rows.pop_front();
        if (rsp_ch.collision !== owed.collision) begin
          $display("%0t: collision mismatch: expected %0b, actual %0b",
                   $time, owed.collision, rsp_ch.collision);
          fail_count++;
        end
        if (rsp_ch.row_bits !== owed.row_bits) begin
          $display("%0t: row_bits mismatch: expected %h, actual %h",
                   $time, owed.row_bits, rsp_ch.row_bits);
          fail_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("xor_sprite_framebuffer_core test failed");
      $finish;
    end
  end

  initial begin
    foreach (shadow_screen[r]) shadow_screen[r] = '0;
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.op          = OP_DRAW;
    req_ch.x_pos       = '0;
    req_ch.y_pos       = '0;
    req_ch.sprite_byte = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_draw_extremes();
    test_other_ops();
    test_random_traffic(200);
    test_drain_pause();
    test_random_traffic(180);

    // Final stretch at full rate on both sides
    req_gaps_on   = 1'b0;
    rsp_stalls_on = 1'b0;
    test_random_traffic(60);

    stop_sending();
    wait_results_drained();
    if (fail_count == 0) begin
      $display("xor_sprite_framebuffer_core test passed");
    end else begin
      $display("xor_sprite_framebuffer_core test failed");
    end
    $finish;
  end

endmodule
